FILE: hdl/gse_pkg.sv
// ----------------------------------------------------------------------------
// gse_pkg: shared types and constants for the gray Sobel edge stream
// Pixel widths, luma weights, CSR codes and reset values, stage flag struct.
// ----------------------------------------------------------------------------
package gse_pkg;

   localparam int PIX_W     = 8;
   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 1;
   localparam int WEIGHT_W  = 16;
   localparam int PROD_W    = PIX_W + WEIGHT_W;
   localparam int DIM_MIN   = 3;

   // CSR register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [CSR_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [CSR_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   // BT.709 luma weights, Q0.16, summing to 65536
   localparam logic [WEIGHT_W-1:0] W_RED   = 16'd13933;
   localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd46871;
   localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd4732;

   localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

   // per-pixel position flags
   typedef struct packed {
      logic emit;      // interior position, produces a result
      logic last_col;
      logic last_row;
   } pos_flags_type;

endpackage

FILE: hdl/gse_stream_if.sv
// ----------------------------------------------------------------------------
// gse_stream_if: valid/ready channels of the gray Sobel edge stream
// Pixel request channel and magnitude response channel.
// ----------------------------------------------------------------------------
interface gse_req_if;
   import gse_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;
   logic             frame_start;

   modport source (output valid, red, green, blue, frame_start, input ready);
   modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface gse_rsp_if;
   import gse_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] magnitude;
   logic             end_of_row;
   logic             end_of_frame;

   modport source (output valid, magnitude, end_of_row, end_of_frame, input ready);
   modport sink   (input valid, magnitude, end_of_row, end_of_frame, output ready);
endinterface

FILE: hdl/gray_sobel_edge_stream.sv
// ----------------------------------------------------------------------------
// gray_sobel_edge_stream: RGB to gray, 3x3 Sobel edge magnitude
// Converts raster-order RGB pixels to BT.709 gray, buffers two rows in a
// line store RAM and emits min(|Gx|+|Gy|, 255) for every interior pixel.
// ----------------------------------------------------------------------------
//   channel   dir  handshake     payload
//   req_bus   in   valid/ready   red, green, blue, frame_start
//   rsp_bus   out  valid/ready   magnitude, end_of_row, end_of_frame
//   csr_*     in   write enable  csr_index, csr_write_data (frame_width/height)
//
// One pixel beat per cycle sustained while rsp_bus is not stalled; a result is
// registered in the luma multiply and line store read stage, the window
// register and the output register before it is valid. The whole
// pipeline advances when the output register is empty or being taken, so
// req_bus.ready follows rsp_bus.ready combinationally.
// Synchronous active-high reset clears control state and window, resets CSRs;
// line store contents are undefined until written (read only in rows 0 and 1).
// ----------------------------------------------------------------------------
module gray_sobel_edge_stream #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   gse_req_if.sink                       req_bus,
   gse_rsp_if.source                     rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [gse_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gse_pkg::CSR_W-1:0]     csr_write_data
);
   import gse_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int SUM_W = PIX_W + 2;   // a + 2b + c
   localparam int MAG_W = SUM_W + 1;   // |dx| + |dy|

   // ---------------------------------------------------------------- control
   logic adv;      // whole pipeline moves
   logic accept;   // pixel beat taken
   logic rsp_valid_ff, rsp_valid_in;

   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign accept        = req_bus.valid && adv;

   // ---------------------------------------------------------------- CSRs
   logic [CSR_W-1:0] frame_width_ff, frame_width_in;
   logic [CSR_W-1:0] frame_height_ff, frame_height_in;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_write_data;
            CSR_FRAME_HEIGHT: frame_height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // ---------------------------------------------------------------- position
   logic [CW-1:0] pos_col;
   pos_flags_type pos_flags;

   gse_position #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_position (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .frame_start  (req_bus.frame_start),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .col          (pos_col),
      .flags        (pos_flags)
   );

   // ---------------------------------------------------------------- stage 1
   // luma products registered; line store read issued at the same time
   logic                s1_valid_ff, s1_valid_in;
   pos_flags_type       s1_flags_ff;
   logic [CW-1:0]       s1_col_ff;
   logic [PROD_W-1:0]   prod_r_ff, prod_g_ff, prod_b_ff;

   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flags_ff <= pos_flags;
         s1_col_ff   <= pos_col;
         prod_r_ff   <= PROD_W'(req_bus.red)   * PROD_W'(W_RED);
         prod_g_ff   <= PROD_W'(req_bus.green) * PROD_W'(W_GREEN);
         prod_b_ff   <= PROD_W'(req_bus.blue)  * PROD_W'(W_BLUE);
      end
   end

   // ---------------------------------------------------------------- stage 2
   // gray level, line store read-modify-write, window shift
   logic [PROD_W-1:0]    luma_sum;
   logic [PIX_W-1:0]     gray;
   logic [2*PIX_W-1:0]   ls_rd_data, ls_wr_data;
   logic [PIX_W-1:0]     upper_old, middle_old;
   logic                 ls_wr_en;

   assign luma_sum   = prod_r_ff + prod_g_ff + prod_b_ff;
   assign gray       = luma_sum[PROD_W-1 -: PIX_W];
   assign upper_old  = ls_rd_data[2*PIX_W-1 -: PIX_W];
   assign middle_old = ls_rd_data[PIX_W-1:0];
   assign ls_wr_en   = s1_valid_ff && adv;
   assign ls_wr_data = {middle_old, gray};   // upper <- middle, middle <- gray

   gse_line_store #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (2 * PIX_W)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (pos_col),
      .wr_en   (ls_wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (ls_wr_data),
      .rd_data (ls_rd_data)
   );

   // window [row][col]: row 0 oldest line, col 2 newest column
   logic [PIX_W-1:0] win_ff [3][3];
   logic [PIX_W-1:0] win_in [3][3];
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_eor_ff, s2_eof_ff;

   always_comb begin
      win_in = win_ff;
      if (ls_wr_en) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = upper_old;
         win_in[1][2] = middle_old;
         win_in[2][2] = gray;
      end
   end

   assign s2_valid_in = s1_valid_ff && s1_flags_ff.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
         s2_valid_ff <= 1'b0;
      end else begin
         win_ff <= win_in;
         if (adv) begin
            s2_valid_ff <= s2_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_eor_ff <= s1_flags_ff.last_col;
         s2_eof_ff <= s1_flags_ff.last_col && s1_flags_ff.last_row;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // Sobel gradients from the window, saturated into the output register
   logic [SUM_W-1:0] xp, xn, yp, yn, dx, dy;
   logic [MAG_W-1:0] mag_full;
   logic [PIX_W-1:0] mag_sat;

   always_comb begin
      xp = SUM_W'(win_ff[0][2]) + SUM_W'({win_ff[1][2], 1'b0}) + SUM_W'(win_ff[2][2]);
      xn = SUM_W'(win_ff[0][0]) + SUM_W'({win_ff[1][0], 1'b0}) + SUM_W'(win_ff[2][0]);
      yp = SUM_W'(win_ff[0][0]) + SUM_W'({win_ff[0][1], 1'b0}) + SUM_W'(win_ff[0][2]);
      yn = SUM_W'(win_ff[2][0]) + SUM_W'({win_ff[2][1], 1'b0}) + SUM_W'(win_ff[2][2]);
      dx = (xp > xn) ? xp - xn : xn - xp;
      dy = (yp > yn) ? yp - yn : yn - yp;
      mag_full = MAG_W'(dx) + MAG_W'(dy);
      mag_sat  = (mag_full > MAG_W'(MAG_MAX)) ? MAG_MAX : mag_full[PIX_W-1:0];
   end

   logic [PIX_W-1:0] mag_ff;
   logic             eor_ff, eof_ff;

   assign rsp_valid_in = s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff) begin
         mag_ff <= mag_sat;
         eor_ff <= s2_eor_ff;
         eof_ff <= s2_eof_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.magnitude    = mag_ff;
   assign rsp_bus.end_of_row   = eor_ff;
   assign rsp_bus.end_of_frame = eof_ff;

`ifndef NO_ASSERTIONS
   a_eof_has_eor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && eof_ff) |-> eor_ff)
      else $error("end_of_frame without end_of_row");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted pixel beat did not enter stage 1");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv) |=> (s1_valid_ff && $stable(s1_col_ff)))
      else $error("stalled stage 1 pixel lost");
`endif

endmodule

FILE: hdl/gse_position.sv
// ----------------------------------------------------------------------------
// gse_position: raster position counters
// Tracks column and row of the incoming pixel, clamps the frame size and
// flags interior, last-column and last-row positions.
// ----------------------------------------------------------------------------
module gse_position #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          frame_start,
   input  logic [gse_pkg::CSR_W-1:0]     frame_width,
   input  logic [gse_pkg::CSR_W-1:0]     frame_height,
   output logic [$clog2(MAX_WIDTH)-1:0]  col,
   output gse_pkg::pos_flags_type        flags
);
   import gse_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int EWW = (CW + 1 > CSR_W) ? CW + 1 : CSR_W;
   localparam int EWH = (RW + 1 > CSR_W) ? RW + 1 : CSR_W;

   logic [CW-1:0]  col_ff, col_in, col_cur, w_last;
   logic [RW-1:0]  row_ff, row_in, row_cur, h_last;
   logic [EWW-1:0] w_ext, w_clamp;
   logic [EWH-1:0] h_ext, h_clamp;

   // clamp frame size to 3..MAX
   always_comb begin
      w_ext = EWW'(frame_width);
      h_ext = EWH'(frame_height);
      priority if (w_ext < EWW'(DIM_MIN)) begin
         w_clamp = EWW'(DIM_MIN);
      end else if (w_ext > EWW'(MAX_WIDTH)) begin
         w_clamp = EWW'(MAX_WIDTH);
      end else begin
         w_clamp = w_ext;
      end
      priority if (h_ext < EWH'(DIM_MIN)) begin
         h_clamp = EWH'(DIM_MIN);
      end else if (h_ext > EWH'(MAX_HEIGHT)) begin
         h_clamp = EWH'(MAX_HEIGHT);
      end else begin
         h_clamp = h_ext;
      end
      w_last = CW'(w_clamp - EWW'(1));
      h_last = RW'(h_clamp - EWH'(1));
   end

   always_comb begin
      col_cur        = frame_start ? '0 : col_ff;
      row_cur        = frame_start ? '0 : row_ff;
      flags.last_col = (col_cur >= w_last);
      flags.last_row = (row_cur >= h_last);
      flags.emit     = (row_cur >= RW'(2)) && (col_cur >= CW'(2));
      col_in         = col_ff;
      row_in         = row_ff;
      if (step) begin
         if (flags.last_col) begin
            col_in = '0;
            row_in = flags.last_row ? '0 : row_cur + RW'(1);
         end else begin
            col_in = col_cur + CW'(1);
            row_in = row_cur;
         end
      end
   end

   assign col = col_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

FILE: hdl/gse_line_store.sv
// ----------------------------------------------------------------------------
// gse_line_store: two-row line store
// One synchronous RAM holding {upper, middle} gray levels per column, with
// registered read data and a bypass for a read that meets a same-cycle write.
// ----------------------------------------------------------------------------
module gse_line_store #(
   parameter int DEPTH  = 2048,
   parameter int DATA_W = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] mem_q_ff;
   logic [DATA_W-1:0] wr_last_ff;
   logic              fwd_ff, fwd_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   // last written word, held until the next write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         wr_last_ff <= wr_data;
      end
   end

   always_comb begin
      fwd_in = fwd_ff;
      if (rd_en) begin
         fwd_in = wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

   assign rd_data = fwd_ff ? wr_last_ff : mem_q_ff;

`ifndef NO_ASSERTIONS
   a_bypass_taken: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en && (rd_addr == wr_addr)) |=> fwd_ff)
      else $error("line store: same-address read/write not bypassed");

   a_bypass_data: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en && (rd_addr == wr_addr)) |=> (rd_data == $past(wr_data)))
      else $error("line store: bypassed read data mismatch");
`endif

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for gray_sobel_edge_stream
// Streams RGB pixel beats through the block and predicts every edge result
// with a behavioral luma/Sobel model. Results are compared field by field in
// order. Covers reset geometry, directed patterns, random frames under four
// idle/stall profiles, mid-frame restarts and geometry changes, and the
// clamped extremes of both frame registers.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gse_pkg::*;

   localparam int unsigned MAX_DIM            = 2048;
   localparam int unsigned RESET_FRAME_WIDTH  = 640;
   localparam int unsigned RESET_FRAME_HEIGHT = 480;
   // BT.709 luma weights, Q0.16
   localparam int unsigned LUMA_RED           = 13933;
   localparam int unsigned LUMA_GREEN         = 46871;
   localparam int unsigned LUMA_BLUE          = 4732;
   localparam int unsigned RANDOM_ITEMS       = 500;
   localparam int unsigned DRAIN_CYCLES       = 10;  // pipeline is 3 deep
   localparam int unsigned MAX_REPORTS        = 10;
   localparam int unsigned RUN_LIMIT_NS       = 20_000_000;

   // idle profiles, entry 0 first: none, sender idles, receiver stalls, both
   localparam logic [3:0][7:0] SENDER_IDLE    = {8'd21, 8'd0, 8'd49, 8'd0};
   localparam logic [3:0][7:0] RECEIVER_STALL = {8'd21, 8'd49, 8'd0, 8'd0};

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             frame_start;
   } rgb_beat_type;

   typedef struct packed {
      logic [PIX_W-1:0] magnitude;
      logic             end_of_row;
      logic             end_of_frame;
   } edge_beat_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_write_data;

   gse_req_if req_bus ();
   gse_rsp_if rsp_bus ();

   gray_sobel_edge_stream #(
      .MAX_WIDTH  (MAX_DIM),
      .MAX_HEIGHT (MAX_DIM)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // ---------------------------------------------------------------------------
   // Edge predictor state: its own copy of the line stores, window, position
   // counters and frame registers.
   // ---------------------------------------------------------------------------
   logic [PIX_W-1:0] gray_two_up [MAX_DIM];   // gray two rows above, per column
   logic [PIX_W-1:0] gray_one_up [MAX_DIM];   // gray one row above, per column
   logic [PIX_W-1:0] gray_window [3][3];      // [row][col], col 2 newest
   int unsigned      pix_col = 0;
   int unsigned      pix_row = 0;
   logic [CSR_W-1:0] frame_width_reg  = CSR_W'(RESET_FRAME_WIDTH);
   logic [CSR_W-1:0] frame_height_reg = CSR_W'(RESET_FRAME_HEIGHT);

   edge_beat_type pending_edges [$];   // expected result beats, oldest first
   int unsigned   error_count     = 0;
   int unsigned   sender_idle_pct = 0;
   int unsigned   stall_pct       = 0;

   // ---------------------------------------------------------------------------
   // Clock, and a hard stop in case the block hangs.
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("[gray_sobel_edge_stream] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------
   // frame registers are clamped to 3..MAX_DIM when used
   function automatic int unsigned clamped_dim(logic [CSR_W-1:0] value);
      if (value < DIM_MIN) return DIM_MIN;
      if (value > MAX_DIM) return MAX_DIM;
      return 32'(value);
   endfunction

   // Advances the model by one accepted pixel beat and queues the result
   // beat it causes, if any.
   task automatic predict_edge(input rgb_beat_type px);
      int unsigned   fw, fh, idx, gray, k;
      int unsigned   gx_pos, gx_neg, gy_pos, gy_neg, mag;
      bit            last_col, last_row;
      edge_beat_type want;
      fw = clamped_dim(frame_width_reg);
      fh = clamped_dim(frame_height_reg);
      if (px.frame_start) begin
         pix_col = 0;
         pix_row = 0;
      end
      // weights sum to 1.0 in Q16, so the truncated gray never exceeds 255
      gray = (LUMA_RED * px.red + LUMA_GREEN * px.green + LUMA_BLUE * px.blue) >> 16;
      idx  = (pix_col < MAX_DIM) ? pix_col : MAX_DIM - 1;

      for (k = 0; k < 3; k++) begin
         gray_window[k][0] = gray_window[k][1];
         gray_window[k][1] = gray_window[k][2];
      end
      gray_window[0][2] = gray_two_up[idx];
      gray_window[1][2] = gray_one_up[idx];
      gray_window[2][2] = gray[PIX_W-1:0];
      gray_two_up[idx]  = gray_one_up[idx];
      gray_one_up[idx]  = gray[PIX_W-1:0];

      // a position past a shrunken frame counts as the last one
      last_col = (pix_col >= fw - 1);
      last_row = (pix_row >= fh - 1);

      if (pix_row >= 2 && pix_col >= 2) begin
         gx_pos = gray_window[0][2] + 2 * gray_window[1][2] + gray_window[2][2];
         gx_neg = gray_window[0][0] + 2 * gray_window[1][0] + gray_window[2][0];
         gy_pos = gray_window[0][0] + 2 * gray_window[0][1] + gray_window[0][2];
         gy_neg = gray_window[2][0] + 2 * gray_window[2][1] + gray_window[2][2];
         mag    = ((gx_pos > gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos)
                + ((gy_pos > gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos);
         if (mag > MAG_MAX) mag = 32'(MAG_MAX);
         want.magnitude    = mag[PIX_W-1:0];
         want.end_of_row   = last_col;
         want.end_of_frame = last_col && last_row;
         pending_edges.push_back(want);
      end

      if (last_col) begin
         pix_col = 0;
         pix_row = last_row ? 0 : pix_row + 1;
      end else begin
         pix_col++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result side: random stalls driven at the falling edge, beats checked at
   // the rising edge against the oldest expectation.
   // ---------------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", msg);
   endtask

   task automatic check_field(input string name, input logic [PIX_W-1:0] want,
                              input logic [PIX_W-1:0] got);
      if (got !== want)
         flag_error($sformatf("mismatch on %s: expected %0d, got %0d", name, want, got));
   endtask

   always @(posedge clock) begin
      edge_beat_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_edges.size() == 0) begin
            flag_error($sformatf("unexpected result beat: magnitude %0d eor %0b eof %0b",
                                 rsp_bus.magnitude, rsp_bus.end_of_row,
                                 rsp_bus.end_of_frame));
         end else begin
            want = pending_edges.pop_front();
            check_field("magnitude", want.magnitude, rsp_bus.magnitude);
            check_field("end_of_row", PIX_W'(want.end_of_row), PIX_W'(rsp_bus.end_of_row));
            check_field("end_of_frame", PIX_W'(want.end_of_frame),
                        PIX_W'(rsp_bus.end_of_frame));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Pixel side
   // ---------------------------------------------------------------------------
   function automatic rgb_beat_type make_pixel(input logic [PIX_W-1:0] red,
                                               input logic [PIX_W-1:0] green,
                                               input logic [PIX_W-1:0] blue,
                                               input logic starts_frame);
      rgb_beat_type px;
      px.red         = red;
      px.green       = green;
      px.blue        = blue;
      px.frame_start = starts_frame;
      return px;
   endfunction

   // A third of the pixels are fully random (mostly clipped edges); the rest
   // sit in a flat mid-gray patch so magnitudes spread across the low range.
   function automatic rgb_beat_type random_pixel(input logic starts_frame);
      if ($urandom_range(2) == 0)
         return make_pixel(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
                           PIX_W'($urandom_range(255)), starts_frame);
      return make_pixel(8'd112 + PIX_W'($urandom_range(15)),
                        8'd112 + PIX_W'($urandom_range(15)),
                        8'd112 + PIX_W'($urandom_range(15)), starts_frame);
   endfunction

   // Sends one pixel beat; valid stays high on return so back-to-back beats
   // keep the stream full. Anyone who stops sending must call settle_block.
   task automatic push_pixel(input rgb_beat_type px);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.red         <= px.red;
      req_bus.green       <= px.green;
      req_bus.blue        <= px.blue;
      req_bus.frame_start <= px.frame_start;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_edge(px);
   endtask

   // Stops the stream, waits for every expected beat, then lets pixels that
   // cause no result leave the pipeline before the block is called idle.
   task automatic settle_block();
      int unsigned saved_stall;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      saved_stall = stall_pct;
      stall_pct   = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      stall_pct = saved_stall;
   endtask

   // CSR write; only called with the block idle
   task automatic write_frame_reg(input logic [CSR_IDX_W-1:0] index,
                                  input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_FRAME_WIDTH)
         frame_width_reg = value;
      else
         frame_height_reg = value;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset geometry: counters start at zero without a frame start marker, and
   // the reset width wraps the first row after 640 pixels. Then the width
   // shrinks mid-row below the current column, which must count as the last
   // column, so the next row brings the first results.
   task automatic test_reset_geometry();
      int unsigned i;
      sender_idle_pct = 21;
      stall_pct       = 21;
      for (i = 0; i < RESET_FRAME_WIDTH + 6; i++) push_pixel(random_pixel(1'b0));
      settle_block();
      write_frame_reg(CSR_FRAME_WIDTH, 12'd4);
      for (i = 0; i < 9; i++) push_pixel(random_pixel(1'b0));
      settle_block();
      sender_idle_pct = 0;
      stall_pct       = 0;
   endtask

   // Minimal 3x3 frames with hand-picked pixels.
   task automatic test_directed_frames();
      int unsigned r, c;
      settle_block();
      write_frame_reg(CSR_FRAME_WIDTH, 12'd3);
      write_frame_reg(CSR_FRAME_HEIGHT, 12'd3);
      // white left column on black: horizontal gradient clips at 255
      for (r = 0; r < 3; r++)
         for (c = 0; c < 3; c++)
            push_pixel(make_pixel((c == 0) ? 8'd255 : 8'd0, (c == 0) ? 8'd255 : 8'd0,
                                  (c == 0) ? 8'd255 : 8'd0, (r == 0 && c == 0)));
      // two beats of a frame that a mid-frame start marker cuts short
      push_pixel(make_pixel(8'd1, 8'd1, 8'd1, 1'b0));
      push_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
      // rows of pure red, pure green, pure blue: one weight per row
      for (r = 0; r < 3; r++)
         for (c = 0; c < 3; c++)
            push_pixel(make_pixel((r == 0) ? 8'd255 : 8'd0, (r == 1) ? 8'd255 : 8'd0,
                                  (r == 2) ? 8'd255 : 8'd0, (r == 0 && c == 0)));
      settle_block();
   endtask

   // Small random frames under each idle profile. New geometry always opens
   // with a frame start, so a wider frame never reads columns the line stores
   // have not seen. Same-geometry frames either wrap or restart. Occasional
   // mid-frame pauses drain the block and may change the height or narrow
   // the width; stray start markers restart the counters mid-frame.
   task automatic test_random_frames();
      int unsigned      sent, fw, fh, npix, i, prof;
      bit               new_geom;
      logic             starts;
      logic [CSR_W-1:0] value;
      for (prof = 0; prof < 4; prof++) begin
         sender_idle_pct = 32'(SENDER_IDLE[prof]);
         stall_pct       = 32'(RECEIVER_STALL[prof]);
         sent            = 0;
         while (sent < RANDOM_ITEMS / 4) begin
            new_geom = ($urandom_range(3) != 0);
            if (new_geom) begin
               settle_block();
               // now and then a width below the legal range, clamped to 3
               value = ($urandom_range(9) == 0) ? CSR_W'($urandom_range(2))
                                                : CSR_W'($urandom_range(12, 3));
               write_frame_reg(CSR_FRAME_WIDTH, value);
               value = CSR_W'($urandom_range(6, 3));
               write_frame_reg(CSR_FRAME_HEIGHT, value);
            end
            fw   = clamped_dim(frame_width_reg);
            fh   = clamped_dim(frame_height_reg);
            npix = fw * fh;
            for (i = 0; i < npix; i++) begin
               if (i == npix / 2 && $urandom_range(7) == 0) begin
                  settle_block();
                  case ($urandom_range(2))
                     0: begin
                        value = CSR_W'($urandom_range(6, 3));
                        write_frame_reg(CSR_FRAME_HEIGHT, value);
                     end
                     1: begin
                        value = CSR_W'($urandom_range(fw, 3));
                        write_frame_reg(CSR_FRAME_WIDTH, value);
                     end
                     default: ;
                  endcase
               end
               if (i == 0)
                  starts = new_geom || ($urandom_range(1) == 1);
               else
                  starts = ($urandom_range(49) == 0);
               push_pixel(random_pixel(starts));
            end
            sent += npix;
         end
      end
      settle_block();
      sender_idle_pct = 0;
      stall_pct       = 0;
   endtask

   // Register extremes: widths and heights below the legal range clamp to 3,
   // and an all-ones height clamps to the tallest frame, so a three-column
   // strip runs many rows without reaching its last one.
   task automatic test_size_extremes();
      int unsigned i;
      settle_block();
      write_frame_reg(CSR_FRAME_WIDTH, 12'd1);
      write_frame_reg(CSR_FRAME_HEIGHT, 12'd0);
      for (i = 0; i < 27; i++) push_pixel(random_pixel(i == 0));
      settle_block();
      write_frame_reg(CSR_FRAME_WIDTH, 12'd0);
      write_frame_reg(CSR_FRAME_HEIGHT, 12'hFFF);
      for (i = 0; i < 60; i++) push_pixel(random_pixel(i == 0));
      settle_block();
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int r, c;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.red         = '0;
      req_bus.green       = '0;
      req_bus.blue        = '0;
      req_bus.frame_start = 1'b0;
      csr_write_enable    = 1'b0;
      csr_index           = CSR_FRAME_WIDTH;
      csr_write_data      = '0;
      for (r = 0; r < 3; r++)
         for (c = 0; c < 3; c++)
            gray_window[r][c] = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_geometry();
      test_directed_frames();
      test_random_frames();
      test_size_extremes();

      // settle_block has already waited out every expected beat
      if (error_count == 0) begin
         $display("[gray_sobel_edge_stream] OK");
      end else begin
         $display("[gray_sobel_edge_stream] ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/gse_pkg.sv
hdl/gse_stream_if.sv
hdl/gse_position.sv
hdl/gse_line_store.sv
hdl/gray_sobel_edge_stream.sv
test/tb_top.sv
